### hdl/hed_pkg.sv
// Shared types, codes and constants for the HTML entity decoder.
package hed_pkg;

  localparam int unsigned CNT_W = 3;  // up to six output bytes per input byte

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_AMP  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_NAME = 2'd3;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;   // input transaction accepted
    logic             emit;   // load output register with byte idx
    logic             last;   // this is the final byte of the run
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] cnt;    // output bytes planned for the current input byte
  } dp_stat_t;

endpackage

### hdl/hed_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface hed_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/hed_dp.sv
// Datapath: decode state, emission plan and output payload register.
module hed_dp (
  input  logic                clk,
  input  logic                rst,
  input  hed_pkg::in_item_t   item,
  input  hed_pkg::dp_cmd_t    cmd,
  output hed_pkg::dp_stat_t   stat,
  output hed_pkg::out_item_t  result
);

  logic [1:0] mode, mode_next;
  logic [7:0] acc, acc_next;
  logic [7:0] name_buf [4];
  logic [2:0] name_len, name_len_next;
  logic       buf_we;
  logic [1:0] buf_wa;

  // plan for the accepted byte: ['&'] [name bytes] [byte a] [byte b]
  logic                     p_amp, p_a_en, p_b_en, p_end;
  logic [2:0]               p_k;
  logic [7:0]               p_a, p_b;
  logic [hed_pkg::CNT_W-1:0] p_cnt;

  logic                     n_amp, n_a_en, n_b_en;
  logic [2:0]               n_k;
  logic [7:0]               n_a, n_b;

  logic [7:0] out_byte;
  logic       run_end, text_end;
  logic [7:0] sel_byte;

  function automatic logic [8:0] name_lookup(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [2:0] len);
    logic [8:0] r;
    r = 9'd0;
    if (len == 3'd3 && b0 == 8'h61 && b1 == 8'h6D && b2 == 8'h70)
      r = {1'b1, hed_pkg::CH_AMP};
    else if (len == 3'd4 && b0 == 8'h71 && b1 == 8'h75 && b2 == 8'h6F && b3 == 8'h74)
      r = {1'b1, hed_pkg::CH_QUOTE};
    else if (len == 3'd2 && b0 == 8'h6C && b1 == 8'h74)
      r = {1'b1, hed_pkg::CH_LT};
    else if (len == 3'd2 && b0 == 8'h67 && b1 == 8'h74)
      r = {1'b1, hed_pkg::CH_GT};
    return r;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       e, is_dig, is_aln, tb_emit;
    logic [1:0] tb_mode;
    logic [7:0] acc_mul;
    logic [7:0] nb [4];
    logic [8:0] hit_cur, hit_new;

    c = item.in_byte;
    e = item.string_end;
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    is_aln = is_dig || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    tb_emit = !(c == hed_pkg::CH_AMP && !e);
    tb_mode = tb_emit ? hed_pkg::MODE_TEXT : hed_pkg::MODE_AMP;
    acc_mul = (acc << 3) + (acc << 1) + (c - hed_pkg::CH_ZERO);
    nb = name_buf;
    nb[name_len[1:0]] = c;
    hit_cur = name_lookup(name_buf[0], name_buf[1], name_buf[2], name_buf[3], name_len);
    hit_new = name_lookup(nb[0], nb[1], nb[2], nb[3], name_len + 3'd1);

    mode_next = mode;
    acc_next = acc;
    name_len_next = name_len;
    buf_we = 1'b0;
    buf_wa = name_len[1:0];
    n_amp = 1'b0;
    n_k = 3'd0;
    n_a_en = 1'b0;
    n_a = c;
    n_b_en = 1'b0;
    n_b = c;

    unique case (mode)
      hed_pkg::MODE_AMP: begin
        if (c == hed_pkg::CH_HASH) begin
          if (e) begin
            n_amp = 1'b1;
            n_a_en = 1'b1;
            mode_next = hed_pkg::MODE_TEXT;
          end else begin
            acc_next = 8'd0;
            mode_next = hed_pkg::MODE_NUM;
          end
        end else if (is_aln) begin
          buf_we = 1'b1;
          buf_wa = 2'd0;
          name_len_next = 3'd1;
          if (e) begin
            n_amp = 1'b1;
            n_a_en = 1'b1;
            mode_next = hed_pkg::MODE_TEXT;
          end else begin
            mode_next = hed_pkg::MODE_NAME;
          end
        end else begin
          n_amp = 1'b1;
          n_a_en = tb_emit;
          mode_next = tb_mode;
        end
      end
      hed_pkg::MODE_NUM: begin
        if (is_dig) begin
          acc_next = acc_mul;
          if (e) begin
            n_a_en = 1'b1;
            n_a = acc_mul;
            mode_next = hed_pkg::MODE_TEXT;
          end
        end else begin
          n_a_en = 1'b1;
          n_a = acc;
          mode_next = hed_pkg::MODE_TEXT;
          if (c != hed_pkg::CH_SEMI) begin
            n_b_en = tb_emit;
            mode_next = tb_mode;
          end
        end
      end
      hed_pkg::MODE_NAME: begin
        if (is_aln) begin
          if (name_len[2]) begin
            // fifth name character: give up and pass everything through
            n_amp = 1'b1;
            n_k = 3'd4;
            n_a_en = 1'b1;
            mode_next = hed_pkg::MODE_TEXT;
          end else begin
            buf_we = 1'b1;
            name_len_next = name_len + 3'd1;
            if (e) begin
              mode_next = hed_pkg::MODE_TEXT;
              if (hit_new[8]) begin
                n_a_en = 1'b1;
                n_a = hit_new[7:0];
              end else begin
                n_amp = 1'b1;
                n_k = name_len + 3'd1;
              end
            end
          end
        end else begin
          mode_next = hed_pkg::MODE_TEXT;
          if (hit_cur[8]) begin
            n_a_en = 1'b1;
            n_a = hit_cur[7:0];
            if (c != hed_pkg::CH_SEMI) begin
              n_b_en = tb_emit;
              mode_next = tb_mode;
            end
          end else begin
            n_amp = 1'b1;
            n_k = name_len;
            n_b_en = tb_emit;
            mode_next = tb_mode;
          end
        end
      end
      default: begin
        n_a_en = tb_emit;
        mode_next = tb_mode;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hed_pkg::MODE_TEXT;
      acc <= 8'd0;
      name_len <= 3'd0;
      p_amp <= 1'b0;
      p_k <= 3'd0;
      p_a_en <= 1'b0;
      p_a <= 8'd0;
      p_b_en <= 1'b0;
      p_b <= 8'd0;
      p_end <= 1'b0;
      p_cnt <= '0;
    end else if (cmd.load) begin
      mode <= mode_next;
      acc <= acc_next;
      name_len <= name_len_next;
      p_amp <= n_amp;
      p_k <= n_k;
      p_a_en <= n_a_en;
      p_a <= n_a;
      p_b_en <= n_b_en;
      p_b <= n_b;
      p_end <= item.string_end;
      p_cnt <= hed_pkg::CNT_W'({2'd0, n_amp} + n_k + {2'd0, n_a_en} + {2'd0, n_b_en});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && buf_we) begin
      name_buf[buf_wa] <= item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= sel_byte;
      run_end <= cmd.last;
      text_end <= cmd.last & p_end;
    end
  end

  always_comb begin
    logic [2:0] j, m;
    j = cmd.idx - {2'd0, p_amp};
    m = j - p_k;
    if (p_amp && cmd.idx == 3'd0)
      sel_byte = hed_pkg::CH_AMP;
    else if (j < p_k)
      sel_byte = name_buf[j[1:0]];
    else if (p_a_en && m == 3'd0)
      sel_byte = p_a;
    else
      sel_byte = p_b;
  end

  assign stat.cnt = p_cnt;
  assign result.out_byte = out_byte;
  assign result.run_end = run_end;
  assign result.text_end = text_end;

endmodule

### hdl/hed_ctrl.sv
// Controller: accept/emit sequencing and output valid flag.
module hed_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hed_pkg::dp_stat_t stat,
  output hed_pkg::dp_cmd_t  cmd,
  output logic              dp_rst
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                      state, state_next;
  logic [hed_pkg::CNT_W-1:0] idx, idx_next;
  logic                      out_valid_next;
  logic                      emit, last;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign emit = (state == ST_EMIT) && (idx != stat.cnt) && (!out_valid || out_ready);
  assign last = emit && (idx == stat.cnt - hed_pkg::CNT_W'(1));

  assign cmd.load = in_valid && in_ready;
  assign cmd.emit = emit;
  assign cmd.last = last;
  assign cmd.idx = idx;
  assign dp_rst = rst;

  always_comb begin
    state_next = state;
    idx_next = idx;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_EMIT;
          idx_next = '0;
        end
      end
      default: begin
        if (emit) idx_next = idx + hed_pkg::CNT_W'(1);
        if (last || idx == stat.cnt) state_next = ST_IDLE;
      end
    endcase
    if (emit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hdl/html_entity_decoder_top.sv
// Top level of the HTML entity decoder.
// Decodes &#digits; and the named references amp, quot, lt and gt in a byte
// stream. Channel enc carries input transactions (in_byte, string_end);
// channel dec carries decoded transactions (out_byte, run_end, text_end).
// Each input byte yields zero to six output bytes; run_end marks the last of
// them and text_end the last byte of a string.
// Timing: an input byte is taken while the controller is idle, then its
// output bytes are loaded into the output register one per cycle while the
// receiver does not stall, as the emit sequencer in the controller steps
// through them. An input byte with no output bytes still passes through
// the emit state. The first output byte is valid once it has been loaded.
// A stalled receiver holds the output register; the sequencer waits and no
// input is taken until all bytes of the current run are loaded. The output
// register lets the next input byte be taken while the last result waits.
// Synchronous reset returns the decoder to normal text mode and drops any
// pending output.
module html_entity_decoder_top (
  input logic clk,
  input logic rst,
  hed_stream_if.sink   enc,
  hed_stream_if.source dec
);

  hed_pkg::dp_cmd_t   cmd;
  hed_pkg::dp_stat_t  stat;
  hed_pkg::in_item_t  item;
  hed_pkg::out_item_t result;
  logic               dp_rst;

  assign item = enc.payload;
  assign dec.payload = result;

  hed_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (enc.valid),
    .in_ready  (enc.ready),
    .out_valid (dec.valid),
    .out_ready (dec.ready),
    .stat      (stat),
    .cmd       (cmd),
    .dp_rst    (dp_rst)
  );

  hed_dp u_dp (
    .clk    (clk),
    .rst    (dp_rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the HTML entity decoder: directed references plus random text.
module tb;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 180;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;

  hed_stream_if #(.payload_t(hed_pkg::in_item_t))  enc_ch ();
  hed_stream_if #(.payload_t(hed_pkg::out_item_t)) dec_ch ();

  html_entity_decoder_top uut (
    .clk (clk),
    .rst (rst),
    .enc (enc_ch),
    .dec (dec_ch)
  );

  // decoder state mirrored by the predictor
  logic [1:0]  dec_mode;
  logic [7:0]  num_acc;
  logic [7:0]  name_buf [4];
  int unsigned name_len;

  logic [7:0]         run_bytes [$];
  hed_pkg::out_item_t expected_out [$];
  logic [7:0]         text_buf [$];

  int mismatch_count;
  int bytes_sent;
  int burst_left;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit name_equals(string s);
    if (name_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (name_buf[i] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit named_ref_value(output logic [7:0] v);
    v = 8'h00;
    if (name_equals("amp")) v = hed_pkg::CH_AMP;
    else if (name_equals("quot")) v = hed_pkg::CH_QUOTE;
    else if (name_equals("lt")) v = hed_pkg::CH_LT;
    else if (name_equals("gt")) v = hed_pkg::CH_GT;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void flush_name();
    run_bytes.push_back(hed_pkg::CH_AMP);
    for (int i = 0; i < name_len; i++) run_bytes.push_back(name_buf[i]);
  endfunction

  function automatic void text_char(logic [7:0] c, logic e);
    if (c == hed_pkg::CH_AMP && !e) begin
      dec_mode = hed_pkg::MODE_AMP;
    end else begin
      dec_mode = hed_pkg::MODE_TEXT;
      run_bytes.push_back(c);
    end
  endfunction

  // Advances the mirrored state by one input byte and queues its decoded bytes.
  function automatic void decode_byte(logic [7:0] c, logic e);
    logic [7:0]         v;
    hed_pkg::out_item_t item;
    run_bytes.delete();
    case (dec_mode)
      hed_pkg::MODE_AMP: begin
        if (c == hed_pkg::CH_HASH) begin
          if (e) begin
            run_bytes.push_back(hed_pkg::CH_AMP);
            run_bytes.push_back(hed_pkg::CH_HASH);
            dec_mode = hed_pkg::MODE_TEXT;
          end else begin
            num_acc  = 8'h00;
            dec_mode = hed_pkg::MODE_NUM;
          end
        end else if (is_alnum(c)) begin
          name_buf[0] = c;
          name_len    = 1;
          dec_mode    = hed_pkg::MODE_NAME;
          if (e) begin
            flush_name();
            dec_mode = hed_pkg::MODE_TEXT;
          end
        end else begin
          run_bytes.push_back(hed_pkg::CH_AMP);
          text_char(c, e);
        end
      end
      hed_pkg::MODE_NUM: begin
        if (is_digit(c)) begin
          num_acc = num_acc * 8'd10 + (c - hed_pkg::CH_ZERO);  // wraps mod 256
          if (e) begin
            run_bytes.push_back(num_acc);
            dec_mode = hed_pkg::MODE_TEXT;
          end
        end else begin
          run_bytes.push_back(num_acc);
          dec_mode = hed_pkg::MODE_TEXT;
          if (c != hed_pkg::CH_SEMI) text_char(c, e);
        end
      end
      hed_pkg::MODE_NAME: begin
        if (is_alnum(c)) begin
          if (name_len >= 4) begin
            // too long for any known entity: give it all back
            flush_name();
            run_bytes.push_back(c);
            dec_mode = hed_pkg::MODE_TEXT;
          end else begin
            name_buf[name_len] = c;
            name_len++;
            if (e) begin
              if (named_ref_value(v)) run_bytes.push_back(v);
              else flush_name();
              dec_mode = hed_pkg::MODE_TEXT;
            end
          end
        end else begin
          dec_mode = hed_pkg::MODE_TEXT;
          if (named_ref_value(v)) begin
            run_bytes.push_back(v);
            if (c != hed_pkg::CH_SEMI) text_char(c, e);
          end else begin
            flush_name();
            text_char(c, e);
          end
        end
      end
      default: text_char(c, e);
    endcase
    foreach (run_bytes[i]) begin
      item.out_byte = run_bytes[i];
      item.run_end  = (i == run_bytes.size() - 1);
      item.text_end = item.run_end & e;
      expected_out.push_back(item);
    end
  endfunction

  // One input transaction; the sender idles between bursts of random length.
  task automatic send_byte(logic [7:0] c, logic e);
    if (burst_left == 0) begin
      enc_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    enc_ch.valid   <= 1'b1;
    enc_ch.payload <= hed_pkg::in_item_t'{in_byte: c, string_end: e};
    do @(posedge clk); while (!enc_ch.ready);
    decode_byte(c, e);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_buf();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_buf();
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(2))
      0:       return 8'(8'h30 + $urandom_range(9));
      1:       return 8'(8'h41 + $urandom_range(25));
      default: return 8'(8'h61 + $urandom_range(25));
    endcase
  endfunction

  function automatic void add_terminator();
    case ($urandom_range(3))
      0:       text_buf.push_back(hed_pkg::CH_SEMI);
      1:       text_buf.push_back(8'($urandom_range(255)));
      default: ;  // run straight into the next piece
    endcase
  endfunction

  function automatic void add_piece();
    string ent;
    int    pos;
    case ($urandom_range(9))
      0, 1, 2: text_buf.push_back(8'($urandom_range(255)));
      3, 4: begin
        text_buf.push_back(hed_pkg::CH_AMP);
        text_buf.push_back(hed_pkg::CH_HASH);
        repeat ($urandom_range(4)) text_buf.push_back(8'(8'h30 + $urandom_range(9)));
        add_terminator();
      end
      5, 6: begin
        case ($urandom_range(3))
          0:       ent = "amp";
          1:       ent = "quot";
          2:       ent = "lt";
          default: ent = "gt";
        endcase
        if ($urandom_range(4) == 0) begin
          pos = $urandom_range(ent.len() - 1);
          ent[pos] = ent[pos] ^ 8'h20;  // case matters
        end
        text_buf.push_back(hed_pkg::CH_AMP);
        for (int i = 0; i < ent.len(); i++) text_buf.push_back(ent[i]);
        add_terminator();
      end
      7: begin
        text_buf.push_back(hed_pkg::CH_AMP);
        repeat ($urandom_range(6, 1)) text_buf.push_back(rand_alnum());
        add_terminator();
      end
      8: begin
        text_buf.push_back(hed_pkg::CH_AMP);
        if ($urandom_range(1)) text_buf.push_back(hed_pkg::CH_HASH);
        else text_buf.push_back(8'($urandom_range(255)));
      end
      default: repeat ($urandom_range(3, 1)) text_buf.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_numeric_refs();
    send_text("&#299;");
    send_text("&#");
    send_text("&#q");
  endtask

  task automatic test_named_refs();
    send_text("&quot;");
    send_text("&abcde");
    send_text("&lt");
    send_text("&&");
  endtask

  task automatic test_random_streams();
    int target;
    target = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < target) begin
      text_buf.delete();
      repeat ($urandom_range(5, 1)) add_piece();
      send_buf();
    end
  endtask

  // Receiver stalls in segments: some stretches never stall, others often.
  initial begin : rx_stall
    int stall_pct;
    int seg_left;
    dec_ch.ready = 1'b0;
    stall_pct    = 0;
    seg_left     = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        case ($urandom_range(3))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
        seg_left = $urandom_range(150, 20);
      end
      seg_left--;
      dec_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_out
    hed_pkg::out_item_t want;
    if (!rst && dec_ch.valid && dec_ch.ready) begin
      if (expected_out.size() == 0) begin
        $error("out_byte: expected none, got %h", dec_ch.payload.out_byte);
        mismatch_count++;
      end else begin
        want = expected_out.pop_front();
        if (dec_ch.payload.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, dec_ch.payload.out_byte);
          mismatch_count++;
        end
        if (dec_ch.payload.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, dec_ch.payload.run_end);
          mismatch_count++;
        end
        if (dec_ch.payload.text_end !== want.text_end) begin
          $error("text_end: expected %b, got %b", want.text_end, dec_ch.payload.text_end);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any transaction on either channel counts as progress
  always @(posedge clk) begin
    if ((enc_ch.valid && enc_ch.ready) || (dec_ch.valid && dec_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    enc_ch.valid   = 1'b0;
    enc_ch.payload = '0;
    mismatch_count = 0;
    bytes_sent     = 0;
    burst_left     = 0;
    dec_mode       = hed_pkg::MODE_TEXT;
    num_acc        = 8'h00;
    name_len       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_bytes();
    test_numeric_refs();
    test_named_refs();
    test_random_streams();

    enc_ch.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
